FILE: rtl/umx_pkg.sv
// ----------------------------------------------------------------------------
// umx_pkg
// Shared types and constants for the universal machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package umx_pkg;

  localparam int XLEN        = 32;
  localparam int RAW         = 3;            // register index width
  localparam int NREG        = 8;
  localparam int OP_LSB      = 28;
  localparam int LV_BITS     = 25;
  localparam int DIV_CNT_W   = 6;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 144;

  localparam logic [XLEN-1:0] ALL_ONES = '1;

  typedef enum logic [3:0] {
    OP_CMOV     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_STORE    = 4'd2,
    OP_ADD      = 4'd3,
    OP_MUL      = 4'd4,
    OP_DIV      = 4'd5,
    OP_NAND     = 4'd6,
    OP_HALT     = 4'd7,
    OP_MAP      = 4'd8,
    OP_UNMAP    = 4'd9,
    OP_OUTPUT   = 4'd10,
    OP_INPUT    = 4'd11,
    OP_LOADPROG = 4'd12,
    OP_LOADVAL  = 4'd13
  } opcode_e;

  typedef enum logic [1:0] {
    ST_STOP = 2'd0,
    ST_CONT = 2'd1,
    ST_HALT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MOP_NONE     = 3'd0,
    MOP_LOAD     = 3'd1,
    MOP_STORE    = 3'd2,
    MOP_MAP      = 3'd3,
    MOP_UNMAP    = 3'd4,
    MOP_LOADPROG = 3'd5
  } mem_op_e;

  typedef struct packed {
    logic            en;
    logic [RAW-1:0]  addr;
    logic [XLEN-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic            start;
    logic [XLEN-1:0] dividend;
    logic [XLEN-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/umx_regfile.sv
// ----------------------------------------------------------------------------
// umx_regfile
// Eight-entry register file: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module umx_regfile (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [umx_pkg::RAW-1:0]     rd_addr0_i,
  input  wire logic [umx_pkg::RAW-1:0]     rd_addr1_i,
  input  wire umx_pkg::rf_wr_t             wr_i,
  output logic      [umx_pkg::XLEN-1:0]    rd_data0_o,
  output logic      [umx_pkg::XLEN-1:0]    rd_data1_o
);

  logic [umx_pkg::XLEN-1:0] mem_q [umx_pkg::NREG];
  logic [umx_pkg::NREG-1:0] valid_q;
  logic [umx_pkg::XLEN-1:0] rd_data0_q, rd_data1_q;

  // an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data0_q <= valid_q[rd_addr0_i] ? mem_q[rd_addr0_i] : '0;
    rd_data1_q <= valid_q[rd_addr1_i] ? mem_q[rd_addr1_i] : '0;
  end

  assign rd_data0_o = rd_data0_q;
  assign rd_data1_o = rd_data1_q;

endmodule

`default_nettype wire

FILE: rtl/umx_div.sv
// ----------------------------------------------------------------------------
// umx_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module umx_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire umx_pkg::div_req_t req_i,
  output umx_pkg::div_rsp_t      rsp_o
);

  logic                            busy_q, done_q;
  logic [umx_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [umx_pkg::XLEN-1:0]        rem_q, quo_q, divisor_q;
  logic [umx_pkg::XLEN:0]          shl, diff;

  assign shl  = {rem_q, quo_q[umx_pkg::XLEN-1]};
  assign diff = shl - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= umx_pkg::DIV_CNT_W'(umx_pkg::XLEN);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == umx_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[umx_pkg::XLEN]) begin
        rem_q <= diff[umx_pkg::XLEN-1:0];
        quo_q <= {quo_q[umx_pkg::XLEN-2:0], 1'b1};
      end else begin
        rem_q <= shl[umx_pkg::XLEN-1:0];
        quo_q <= {quo_q[umx_pkg::XLEN-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/register_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit_core
// Execute unit of the 14-opcode 32-bit universal machine.
// ----------------------------------------------------------------------------
// One word in gives one word out. Each word passes through accept with read of
// B and C, read A, execute and commit, with the result register loaded at
// commit. A divide by a nonzero value also waits, between execute and commit, for
// the one-bit-per-cycle divider. A stalled result channel holds the unit at
// commit. The register file is a synchronous RAM with registered read ports,
// and the next word is taken only after the previous one has committed its
// write-back, so no forwarding is needed. Segment operations
// leave as a request on the output with the operand values; their data comes
// back as a write-back word (tuser = 1). A finished result may sit in the
// output register while the next word is accepted.
`default_nettype none

module register_machine_execute_unit_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // instr_word, in_byte, in_eof, program_length, wb_reg, wb_value, zero pad
  input  wire logic [umx_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // kind
  input  wire logic                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // pc_value, out_valid, out_byte, mem_op, dest_reg, val_a, val_b, val_c, pad
  output logic      [umx_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // status
  output logic      [1:0]                           m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_DIV,
    S_COMMIT
  } state_e;

  localparam int XLEN = umx_pkg::XLEN;
  localparam int RAW  = umx_pkg::RAW;

  state_e                         state_q;
  logic [XLEN-1:0]                pc_q, pc_nxt_q;
  logic                           m_tvalid_q;
  logic [umx_pkg::OUT_TDATA_W-1:0] m_tdata_q;
  umx_pkg::status_e               m_status_q, status_q;

  // latched input word
  logic                           kind_q;
  logic [XLEN-1:0]                instr_q, len_q, wbval_q;
  logic [7:0]                     byte_q;
  logic                           eof_q;
  logic [RAW-1:0]                 wbreg_q;

  logic [XLEN-1:0]                ra_q, rb_q, rc_q;
  logic                           wen_q;
  logic [RAW-1:0]                 waddr_q;
  logic [XLEN-1:0]                wdata_q;

  logic [RAW-1:0]                 rd_addr0, rd_addr1;
  logic [XLEN-1:0]                rd_data0, rd_data1;
  umx_pkg::rf_wr_t                rf_wr;
  umx_pkg::div_req_t              div_req;
  umx_pkg::div_rsp_t              div_rsp;

  logic                           accept, commit;

  umx_pkg::opcode_e               op;
  logic [RAW-1:0]                 fa, fb, fc;

  assign op = umx_pkg::opcode_e'(instr_q[umx_pkg::OP_LSB +: 4]);
  assign fa = instr_q[8:6];
  assign fb = instr_q[5:3];
  assign fc = instr_q[2:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == S_COMMIT) && (!m_tvalid_q || m_axis_tready);

  // port 0 reads B at accept and A afterwards, port 1 reads C
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr0 = s_axis_tdata[5:3];
      rd_addr1 = s_axis_tdata[2:0];
    end else begin
      rd_addr0 = fa;
      rd_addr1 = fc;
    end
  end

  assign rf_wr.en   = commit && wen_q;
  assign rf_wr.addr = waddr_q;
  assign rf_wr.data = wdata_q;

  umx_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .wr_i       (rf_wr),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

  // ---------------------------------------------------------------- execute
  logic                 adv_ok;
  logic [XLEN-1:0]      adv_pc;
  umx_pkg::status_e     adv_st;
  logic                 ex_wen, ex_div;
  logic [RAW-1:0]       ex_waddr;
  logic [XLEN-1:0]      ex_wdata, ex_pc;
  umx_pkg::status_e     ex_st;

  assign adv_ok = !(pc_q == umx_pkg::ALL_ONES || pc_q == len_q);
  assign adv_pc = adv_ok ? pc_q + 1'b1 : pc_q;
  assign adv_st = adv_ok ? umx_pkg::ST_CONT : umx_pkg::ST_STOP;

  always_comb begin
    ex_wen   = 1'b0;
    ex_div   = 1'b0;
    ex_waddr = fa;
    ex_wdata = rb_q;
    ex_st    = adv_st;
    ex_pc    = adv_pc;
    if (kind_q) begin
      ex_wen   = 1'b1;
      ex_waddr = wbreg_q;
      ex_wdata = wbval_q;
      ex_st    = umx_pkg::ST_CONT;
      ex_pc    = pc_q;
    end else begin
      case (op)
        umx_pkg::OP_CMOV: begin
          ex_wen = (rc_q != '0);
        end
        umx_pkg::OP_LOAD, umx_pkg::OP_STORE, umx_pkg::OP_MAP, umx_pkg::OP_UNMAP,
        umx_pkg::OP_OUTPUT: begin
          ex_wen = 1'b0;
        end
        umx_pkg::OP_ADD: begin
          ex_wen   = 1'b1;
          ex_wdata = rb_q + rc_q;
        end
        umx_pkg::OP_MUL: begin
          ex_wen   = 1'b1;
          ex_wdata = rb_q * rc_q;
        end
        umx_pkg::OP_DIV: begin
          if (rc_q == '0) begin
            ex_st = umx_pkg::ST_STOP;
            ex_pc = pc_q;
          end else begin
            ex_wen = 1'b1;
            ex_div = 1'b1;
          end
        end
        umx_pkg::OP_NAND: begin
          ex_wen   = 1'b1;
          ex_wdata = ~(rb_q & rc_q);
        end
        umx_pkg::OP_HALT: begin
          ex_st = umx_pkg::ST_HALT;
          ex_pc = pc_q;
        end
        umx_pkg::OP_INPUT: begin
          ex_wen   = 1'b1;
          ex_waddr = fc;
          ex_wdata = eof_q ? umx_pkg::ALL_ONES : {{(XLEN-8){1'b0}}, byte_q};
        end
        umx_pkg::OP_LOADPROG: begin
          ex_st = umx_pkg::ST_CONT;
          ex_pc = rc_q;
        end
        umx_pkg::OP_LOADVAL: begin
          ex_wen   = 1'b1;
          ex_waddr = instr_q[umx_pkg::LV_BITS +: RAW];
          ex_wdata = {{(XLEN-umx_pkg::LV_BITS){1'b0}}, instr_q[umx_pkg::LV_BITS-1:0]};
        end
        default: begin
          // opcodes 14 and 15: fault, nothing changes
          ex_st = umx_pkg::ST_STOP;
          ex_pc = pc_q;
        end
      endcase
    end
  end

  assign div_req.start    = (state_q == S_EXEC) && ex_div;
  assign div_req.dividend = rb_q;
  assign div_req.divisor  = rc_q;

  umx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- result
  logic                 res_oval;
  logic [7:0]           res_obyte;
  umx_pkg::mem_op_e     res_mop;
  logic [RAW-1:0]       res_dest;
  logic                 res_req;

  always_comb begin
    res_mop  = umx_pkg::MOP_NONE;
    res_dest = '0;
    res_oval = 1'b0;
    if (!kind_q) begin
      case (op)
        umx_pkg::OP_LOAD: begin
          res_mop  = umx_pkg::MOP_LOAD;
          res_dest = fa;
        end
        umx_pkg::OP_STORE:    res_mop = umx_pkg::MOP_STORE;
        umx_pkg::OP_MAP: begin
          res_mop  = umx_pkg::MOP_MAP;
          res_dest = fb;
        end
        umx_pkg::OP_UNMAP:    res_mop  = umx_pkg::MOP_UNMAP;
        umx_pkg::OP_LOADPROG: res_mop  = umx_pkg::MOP_LOADPROG;
        umx_pkg::OP_OUTPUT:   res_oval = 1'b1;
        default:              res_mop  = umx_pkg::MOP_NONE;
      endcase
    end
  end

  assign res_req   = (res_mop != umx_pkg::MOP_NONE);
  assign res_obyte = res_oval ? rc_q[7:0] : 8'h00;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pc_q       <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_status_q <= umx_pkg::ST_STOP;
    end else begin
      if (m_tvalid_q && m_axis_tready && !commit) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RD1;
          end
        end
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= S_EXEC;
        S_EXEC: state_q <= ex_div ? S_DIV : S_COMMIT;
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            state_q    <= S_IDLE;
            pc_q       <= pc_nxt_q;
            m_tvalid_q <= 1'b1;
            m_status_q <= status_q;
            m_tdata_q  <= {1'b0,
                           res_req ? rc_q : {XLEN{1'b0}},
                           res_req ? rb_q : {XLEN{1'b0}},
                           res_req ? ra_q : {XLEN{1'b0}},
                           res_dest, res_mop, res_obyte, res_oval, pc_nxt_q};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= s_axis_tuser;
      instr_q <= s_axis_tdata[31:0];
      byte_q  <= s_axis_tdata[39:32];
      eof_q   <= s_axis_tdata[40];
      len_q   <= s_axis_tdata[72:41];
      wbreg_q <= s_axis_tdata[75:73];
      wbval_q <= s_axis_tdata[107:76];
    end
    if (state_q == S_RD1) begin
      rb_q <= rd_data0;
      rc_q <= rd_data1;
    end
    if (state_q == S_RD2) begin
      ra_q <= rd_data0;
    end
    if (state_q == S_EXEC) begin
      wen_q    <= ex_wen;
      waddr_q  <= ex_waddr;
      wdata_q  <= ex_wdata;
      status_q <= ex_st;
      pc_nxt_q <= ex_pc;
    end
    if (state_q == S_DIV && div_rsp.done) begin
      wdata_q <= div_rsp.quotient;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_status_q;

`ifndef SYNTHESIS
  a_pc_only_at_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(pc_q))
    else $error("pc changed outside commit");

  a_halt_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_q == umx_pkg::ST_HALT) |=> pc_q == $past(pc_q))
    else $error("halt moved the pc");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside divide wait");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> div_req.divisor != '0)
    else $error("divider started with zero divisor");
`endif

endmodule

`default_nettype wire

FILE: verif/umx_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umx_exec_checker
// Watches both stream channels of the execute unit. Every accepted input
// word is run through a behavioral copy of the register file and program
// counter, and the expected result is queued. Each result word is compared
// field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module umx_exec_checker
  import umx_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [1:0]             m_axis_tuser,
  output int                     fail_count,
  output int                     pending,
  output logic [XLEN-1:0]        pc_now
);

  typedef struct packed {
    status_e         status;
    logic [XLEN-1:0] pc;
    logic            out_valid;
    logic [7:0]      out_byte;
    mem_op_e         mem_op;
    logic [RAW-1:0]  dest;
    logic [XLEN-1:0] val_a;
    logic [XLEN-1:0] val_b;
    logic [XLEN-1:0] val_c;
  } exec_res_t;

  logic [XLEN-1:0] gpr [NREG];
  logic [XLEN-1:0] pc_q;
  exec_res_t       results_due [$];

  // Applies one input word to the model state and builds its result.
  task automatic predict_word(input logic kind, input logic [IN_TDATA_W-1:0] d,
                              output exec_res_t r);
    logic [XLEN-1:0] iw;
    logic [XLEN-1:0] plen;
    logic [RAW-1:0]  ra, rb, rc;
    logic            req;
    logic            adv;
    iw   = d[31:0];
    plen = d[72:41];
    ra   = iw[8:6];
    rb   = iw[5:3];
    rc   = iw[2:0];
    r        = '0;
    r.status = ST_CONT;
    req      = 1'b0;
    adv      = 1'b0;
    if (kind) begin
      gpr[d[75:73]] = d[107:76];
    end else begin
      case (iw[31:28])
        OP_CMOV: begin
          if (gpr[rc] != '0) gpr[ra] = gpr[rb];
          adv = 1'b1;
        end
        OP_LOAD: begin
          r.mem_op = MOP_LOAD;
          r.dest   = ra;
          req      = 1'b1;
          adv      = 1'b1;
        end
        OP_STORE: begin
          r.mem_op = MOP_STORE;
          req      = 1'b1;
          adv      = 1'b1;
        end
        OP_ADD: begin
          gpr[ra] = gpr[rb] + gpr[rc];
          adv     = 1'b1;
        end
        OP_MUL: begin
          gpr[ra] = gpr[rb] * gpr[rc];
          adv     = 1'b1;
        end
        OP_DIV: begin
          if (gpr[rc] == '0) begin
            r.status = ST_STOP;
          end else begin
            gpr[ra] = gpr[rb] / gpr[rc];
            adv     = 1'b1;
          end
        end
        OP_NAND: begin
          gpr[ra] = ~(gpr[rb] & gpr[rc]);
          adv     = 1'b1;
        end
        OP_HALT: begin
          r.status = ST_HALT;
        end
        OP_MAP: begin
          r.mem_op = MOP_MAP;
          r.dest   = rb;
          req      = 1'b1;
          adv      = 1'b1;
        end
        OP_UNMAP: begin
          r.mem_op = MOP_UNMAP;
          req      = 1'b1;
          adv      = 1'b1;
        end
        OP_OUTPUT: begin
          r.out_valid = 1'b1;
          r.out_byte  = gpr[rc][7:0];
          adv         = 1'b1;
        end
        OP_INPUT: begin
          gpr[rc] = d[40] ? ALL_ONES : {24'd0, d[39:32]};
          adv     = 1'b1;
        end
        OP_LOADPROG: begin
          r.mem_op = MOP_LOADPROG;
          req      = 1'b1;
          pc_q     = gpr[rc];
        end
        OP_LOADVAL: begin
          gpr[iw[27:25]] = {7'd0, iw[LV_BITS-1:0]};
          adv            = 1'b1;
        end
        default: begin
          r.status = ST_STOP;
        end
      endcase
    end
    // pc sticks at all ones or at the program bound, which ends the run
    if (adv) begin
      if (pc_q == ALL_ONES || pc_q == plen) r.status = ST_STOP;
      else pc_q = pc_q + 1'b1;
    end
    r.pc = pc_q;
    if (req) begin
      r.val_a = gpr[ra];
      r.val_b = gpr[rb];
      r.val_c = gpr[rc];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exec_res_t exp_r;
    exec_res_t act_r;
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) gpr[i] = '0;
      pc_q = '0;
      results_due.delete();
      fail_count = 0;
      pending    = 0;
      pc_now     = '0;
    end else begin
      // result side first: a word accepted this edge cannot have its result yet
      if (m_axis_tvalid && m_axis_tready) begin
        act_r.status    = status_e'(m_axis_tuser);
        act_r.pc        = m_axis_tdata[31:0];
        act_r.out_valid = m_axis_tdata[32];
        act_r.out_byte  = m_axis_tdata[40:33];
        act_r.mem_op    = mem_op_e'(m_axis_tdata[43:41]);
        act_r.dest      = m_axis_tdata[46:44];
        act_r.val_a     = m_axis_tdata[78:47];
        act_r.val_b     = m_axis_tdata[110:79];
        act_r.val_c     = m_axis_tdata[142:111];
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result word: st=%0d pc=%h", $realtime,
                     act_r.status, act_r.pc);
        end else begin
          exp_r = results_due.pop_front();
          if (act_r.status !== exp_r.status || act_r.pc !== exp_r.pc ||
              act_r.out_valid !== exp_r.out_valid || act_r.out_byte !== exp_r.out_byte ||
              act_r.mem_op !== exp_r.mem_op || act_r.dest !== exp_r.dest ||
              act_r.val_a !== exp_r.val_a || act_r.val_b !== exp_r.val_b ||
              act_r.val_c !== exp_r.val_c) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] exp st=%0d pc=%h ov=%b ob=%h mop=%0d dst=%0d a=%h b=%h c=%h",
                       $realtime, exp_r.status, exp_r.pc, exp_r.out_valid, exp_r.out_byte,
                       exp_r.mem_op, exp_r.dest, exp_r.val_a, exp_r.val_b, exp_r.val_c);
              $display("[%0t] got st=%0d pc=%h ov=%b ob=%h mop=%0d dst=%0d a=%h b=%h c=%h",
                       $realtime, act_r.status, act_r.pc, act_r.out_valid, act_r.out_byte,
                       act_r.mem_op, act_r.dest, act_r.val_a, act_r.val_b, act_r.val_c);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(s_axis_tuser, s_axis_tdata, exp_r);
        results_due.push_back(exp_r);
      end
      pending = results_due.size();
      pc_now  = pc_q;
    end
  end

endmodule

FILE: verif/register_machine_execute_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_execute_unit_core_tb
// Drives instruction and write-back words into the execute unit: a directed
// pass over every opcode and corner case, then random programs under three
// idle mixes on the two channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module register_machine_execute_unit_core_tb;
  import umx_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // instr_word, in_byte, in_eof, program_length, wb_reg, wb_value, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // kind
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // pc_value, out_valid, out_byte, mem_op, dest_reg, val_a, val_b, val_c, pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [1:0]             m_axis_tuser;

  int              fail_count;
  int              pending;
  logic [XLEN-1:0] pc_now;
  int              src_idle_pct = 0;
  int              snk_idle_pct = 0;
  int              words_sent   = 0;
  int              wb_sent      = 0;
  int              quiet_cycles = 0;
  logic [15:0]     ops_hit      = '0;

  register_machine_execute_unit_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  umx_exec_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .pc_now        (pc_now)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // A, B and C fields; the unused middle bits carry noise
  function automatic logic [31:0] abc(logic [3:0] op, logic [2:0] a, logic [2:0] b,
                                      logic [2:0] c);
    return {op, 19'($urandom), a, b, c};
  endfunction

  function automatic logic [31:0] ldval(logic [2:0] a, logic [24:0] v);
    return {OP_LOADVAL, a, v};
  endfunction

  // program bound: sometimes right at the current pc so the run stops
  function automatic logic [31:0] pick_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return pc_now;
    if (sel < 15) return ALL_ONES;
    if (sel < 20) return '0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(4))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic kind, logic [31:0] iw, logic [7:0] ib, logic eof,
                           logic [31:0] plen, logic [2:0] wr, logic [31:0] wv);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'd0, wv, wr, plen, eof, ib, iw};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
    if (kind) wb_sent++;
    else ops_hit[iw[31:28]] = 1'b1;
  endtask

  task automatic issue(logic [31:0] iw);
    send_word(1'b0, iw, 8'($urandom), ($urandom_range(4) == 0), pick_len(), 3'($urandom),
              $urandom);
  endtask

  task automatic write_back(logic [2:0] r, logic [31:0] v);
    send_word(1'b1, $urandom, 8'($urandom), 1'($urandom_range(1)), pick_len(), r, v);
  endtask

  task automatic run_program(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 12) write_back(3'($urandom_range(7)), pick_val());
      else if (sel < 25) issue(ldval(3'($urandom), 25'($urandom)));
      else if (sel < 30) issue($urandom);
      else issue(abc(4'($urandom_range(15)), 3'($urandom), 3'($urandom), 3'($urandom)));
    end
  endtask

  // sender holds off until every outstanding result has drained
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pass
    issue(ldval(3'd1, 25'h1FF_FFFF));
    issue(ldval(3'd7, 25'd3));
    send_word(1'b0, abc(OP_INPUT, 3'd0, 3'd0, 3'd3), 8'hFF, 1'b0, pick_len(), 3'd0, '0);
    send_word(1'b0, abc(OP_INPUT, 3'd0, 3'd0, 3'd4), 8'h00, 1'b1, pick_len(), 3'd7, ALL_ONES);
    issue(abc(OP_ADD, 3'd5, 3'd4, 3'd3));   // wraps
    issue(abc(OP_MUL, 3'd6, 3'd4, 3'd4));
    issue(abc(OP_DIV, 3'd0, 3'd4, 3'd3));
    issue(abc(OP_DIV, 3'd0, 3'd1, 3'd2));   // divide by zero
    issue(abc(OP_NAND, 3'd6, 3'd4, 3'd4));
    issue(abc(OP_CMOV, 3'd6, 3'd1, 3'd2));  // condition zero, no move
    issue(abc(OP_CMOV, 3'd6, 3'd1, 3'd7));
    issue(abc(OP_OUTPUT, 3'd0, 3'd0, 3'd4));
    issue(abc(OP_LOAD, 3'd3, 3'd1, 3'd7));
    issue(abc(OP_STORE, 3'd2, 3'd4, 3'd5));
    issue(abc(OP_MAP, 3'd0, 3'd5, 3'd7));
    issue(abc(OP_UNMAP, 3'd0, 3'd0, 3'd1));
    write_back(3'd5, ALL_ONES);
    write_back(3'd0, '0);
    issue(abc(4'd14, 3'd1, 3'd2, 3'd3));
    issue(abc(4'd15, 3'd7, 3'd7, 3'd7));
    issue(abc(OP_HALT, 3'd0, 3'd0, 3'd0));
    send_word(1'b0, abc(OP_ADD, 3'd2, 3'd2, 3'd2), 8'h00, 1'b0, pc_now, 3'd0, '0);
    issue(abc(OP_LOADPROG, 3'd0, 3'd1, 3'd4));  // pc to all ones
    send_word(1'b0, abc(OP_ADD, 3'd1, 3'd1, 3'd1), 8'h00, 1'b0, 32'd5, 3'd0, '0);
    issue(abc(OP_LOADPROG, 3'd0, 3'd0, 3'd2));  // back to zero

    src_idle_pct = 17;
    snk_idle_pct = 72;
    run_program(140);
    drain();

    src_idle_pct = 72;
    snk_idle_pct = 17;
    run_program(140);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_program(145);

    drain();
    repeat (50) @(negedge clk_i);

    $display("Ran %0d words (%0d write-backs), %0d of 16 opcode codes executed,",
             words_sent, wb_sent, $countones(ops_hit));
    $display("under light, heavy and no idling on the input and result channels.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
